>>> hdl/ctia_pkg.sv
package ctia_pkg;

   localparam int RADIUS_BITS = 12;
   localparam int ID_BITS     = 6;

   typedef logic [RADIUS_BITS-1:0]   radius_type;
   typedef logic [2*RADIUS_BITS-1:0] radius_sq_type;
   typedef logic [ID_BITS-1:0]       track_id_type;

   localparam radius_type RADIUS_RESET = 12'd50;

   typedef struct packed {
      logic valid;
      logic flush;
   } dist_ctrl_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } dist_status_type;

endpackage

>>> hdl/ctia_dist_unit.sv
module ctia_dist_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctia_pkg::dist_ctrl_type        ctrl,
   input  logic [COORD_BITS-1:0]          pos_x,
   input  logic [COORD_BITS-1:0]          pos_y,
   input  logic [COORD_BITS-1:0]          entry_col,
   input  logic [COORD_BITS-1:0]          entry_row,
   input  ctia_pkg::radius_sq_type        radius_sq,
   output ctia_pkg::dist_status_type      status
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 1;
   localparam int R2_W  = 2 * ctia_pkg::RADIUS_BITS;
   localparam int CMP_W = (SUM_W > R2_W) ? SUM_W : R2_W;

   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic [SQ_W-1:0]       sq_x_in;
   logic [SQ_W-1:0]       sq_y_in;
   logic [SQ_W-1:0]       sq_x_ff;
   logic [SQ_W-1:0]       sq_y_ff;
   logic                  vld_in;
   logic                  vld_ff;
   logic [SUM_W-1:0]      dist_sq;
   logic                  in_range;

   always_comb begin
      dx      = (pos_x >= entry_col) ? (pos_x - entry_col) : (entry_col - pos_x);
      dy      = (pos_y >= entry_row) ? (pos_y - entry_row) : (entry_row - pos_y);
      sq_x_in = SQ_W'(dx) * SQ_W'(dx);
      sq_y_in = SQ_W'(dy) * SQ_W'(dy);
      vld_in  = ctrl.valid && !ctrl.flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
   end

   always_comb begin
      dist_sq      = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff);
      in_range     = CMP_W'(dist_sq) < CMP_W'(radius_sq);
      status.valid = vld_ff;
      status.hit   = vld_ff && in_range;
   end

endmodule

>>> hdl/centroid_track_id_assigner_top.sv
// Assigns a track id to each blob centroid. Raise start with a centroid while busy is low;
// the block scans the stored tracks in id order through a registered-read table memory and
// a pipelined squared-distance unit, updates the first track strictly inside the match radius,
// or else appends a new one or, with the table full, flags the centroid dropped, and pulses
// rsp_valid for one cycle with the result. The receiver cannot stall, so it must take rsp_* in
// the cycle rsp_valid is high. rsp_valid is high in the first cycle with busy low, and a new
// transaction can be accepted in that same cycle. csr_write_enable loads the match radius
// (reset 50) and should only be used while busy is low. Table contents need no clearing.
module centroid_track_id_assigner_top #(
   parameter int TABLE_DEPTH = 64,
   parameter int COORD_BITS  = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [COORD_BITS-1:0]        req_centroid_x,
   input  logic [COORD_BITS-1:0]        req_centroid_y,
   output logic                         rsp_valid,
   output ctia_pkg::track_id_type       rsp_track_id,
   output logic                         rsp_is_new,
   output logic                         rsp_dropped,
   input  logic                         csr_write_enable,
   input  ctia_pkg::radius_type         csr_write_data
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = 2 * COORD_BITS;
   localparam int R2_W    = 2 * ctia_pkg::RADIUS_BITS;
   localparam int EXT_W   = IDX_W + ctia_pkg::ID_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // track table
   logic [ENTRY_W-1:0] track_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic                     state_in,  state_ff;
   logic [CNT_W-1:0]         count_in,  count_ff;
   logic [CNT_W-1:0]         rd_idx_in, rd_idx_ff;
   logic                     s1_vld_in, s1_vld_ff;
   logic [IDX_W-1:0]         s1_idx_in, s1_idx_ff;
   logic [IDX_W-1:0]         s2_idx_in, s2_idx_ff;
   logic [COORD_BITS-1:0]    x_in,      x_ff;
   logic [COORD_BITS-1:0]    y_in,      y_ff;
   ctia_pkg::radius_sq_type  r2_in,     r2_ff;
   ctia_pkg::radius_type     radius_in, radius_ff;
   logic                     rsp_valid_in, rsp_valid_ff;
   ctia_pkg::track_id_type   rsp_id_in,    rsp_id_ff;
   logic                     rsp_new_in,   rsp_new_ff;
   logic                     rsp_drop_in,  rsp_drop_ff;

   logic                      accept;
   logic                      scan;
   logic                      hit;
   logic                      issue;
   logic                      drain;
   logic                      room;
   logic [IDX_W-1:0]          sel_idx;
   logic [EXT_W-1:0]          sel_idx_ext;
   ctia_pkg::dist_ctrl_type   dist_ctrl;
   ctia_pkg::dist_status_type dist_status;

   ctia_dist_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (dist_ctrl),
      .pos_x     (x_ff),
      .pos_y     (y_ff),
      .entry_col (rd_data_ff[ENTRY_W-1:COORD_BITS]),
      .entry_row (rd_data_ff[COORD_BITS-1:0]),
      .radius_sq (r2_ff),
      .status    (dist_status)
   );

   always_comb begin
      scan   = (state_ff == ST_SCAN);
      accept = start && !scan;
      hit    = dist_status.hit;
      issue  = scan && (rd_idx_ff < count_ff) && !hit;
      drain  = scan && !hit && (rd_idx_ff == count_ff) && !s1_vld_ff && !dist_status.valid;
      room   = (count_ff < DEPTH_CNT);

      dist_ctrl.valid = s1_vld_ff;
      dist_ctrl.flush = hit;

      state_in = state_ff;
      if (accept) begin
         state_in = ST_SCAN;
      end else if (hit || drain) begin
         state_in = ST_IDLE;
      end

      rd_idx_in = rd_idx_ff;
      if (accept) begin
         rd_idx_in = '0;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end

      s1_vld_in = issue;
      s1_idx_in = rd_idx_ff[IDX_W-1:0];
      s2_idx_in = s1_idx_ff;
      rd_addr   = rd_idx_ff[IDX_W-1:0];

      x_in  = accept ? req_centroid_x : x_ff;
      y_in  = accept ? req_centroid_y : y_ff;
      r2_in = accept ? (R2_W'(radius_ff) * R2_W'(radius_ff)) : r2_ff;

      radius_in = csr_write_enable ? csr_write_data : radius_ff;

      count_in = (drain && room) ? (count_ff + CNT_W'(1)) : count_ff;

      sel_idx     = hit ? s2_idx_ff : count_ff[IDX_W-1:0];
      sel_idx_ext = EXT_W'(sel_idx);

      rsp_valid_in = hit || drain;
      rsp_new_in   = drain && room;
      rsp_drop_in  = drain && !room;
      rsp_id_in    = (hit || room) ? sel_idx_ext[ctia_pkg::ID_BITS-1:0] : '0;

      mem_we  = hit || (drain && room);
      wr_addr = sel_idx;
      wr_data = {x_ff, y_ff};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         track_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= track_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         s1_vld_ff    <= 1'b0;
         radius_ff    <= ctia_pkg::RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         s1_vld_ff    <= s1_vld_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_idx_ff   <= s1_idx_in;
      s2_idx_ff   <= s2_idx_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      r2_ff       <= r2_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign busy         = scan;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_track_id = rsp_id_ff;
   assign rsp_is_new   = rsp_new_ff;
   assign rsp_dropped  = rsp_drop_ff;

`ifndef SYNTHESIS
   a_new_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_drop_ff))
      else $error("result flagged both new and dropped");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("track count beyond table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_drop_ff) |-> (count_ff == DEPTH_CNT))
      else $error("dropped with room in the table");
`endif

endmodule

>>> tb/sv/tb_centroid_track_id_assigner_top.sv
`timescale 1ns / 1ps

module tb_centroid_track_id_assigner_top;

   localparam int TABLE_DEPTH  = 64;
   localparam int COORD_BITS   = 12;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 150;
   localparam int RANDOM_PHASES = 7;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } centroid_type;

   typedef struct packed {
      ctia_pkg::track_id_type track_id;
      logic                   is_new;
      logic                   dropped;
   } track_result_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic                   busy;
   coord_type              req_centroid_x   = '0;
   coord_type              req_centroid_y   = '0;
   logic                   rsp_valid;
   ctia_pkg::track_id_type rsp_track_id;
   logic                   rsp_is_new;
   logic                   rsp_dropped;
   logic                   csr_write_enable = 1'b0;
   ctia_pkg::radius_type   csr_write_data   = '0;

   centroid_type     centroid_queue[$];
   track_result_type track_results_due[$];

   // shadow of the track table
   coord_type            track_col [TABLE_DEPTH];
   coord_type            track_row [TABLE_DEPTH];
   int                   track_count  = 0;
   ctia_pkg::radius_type model_radius = ctia_pkg::RADIUS_RESET;

   bit taken       = 1'b0;
   bit no_gap      = 1'b0;
   int gap_left    = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   centroid_track_id_assigner_top #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_centroid_x   (req_centroid_x),
      .req_centroid_y   (req_centroid_y),
      .rsp_valid        (rsp_valid),
      .rsp_track_id     (rsp_track_id),
      .rsp_is_new       (rsp_is_new),
      .rsp_dropped      (rsp_dropped),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // first stored track strictly inside the radius, lowest id first, then update, append or drop
   function automatic track_result_type assign_track(coord_type x, coord_type y);
      track_result_type res;
      int               i;
      int               dx;
      int               dy;
      int               r2;
      bit               hit;
      res = '0;
      hit = 1'b0;
      r2  = int'(model_radius) * int'(model_radius);
      for (i = 0; i < track_count; i++) begin
         if (!hit) begin
            dx = int'(x) - int'(track_col[i]);
            dy = int'(y) - int'(track_row[i]);
            if (dx * dx + dy * dy < r2) begin
               hit          = 1'b1;
               track_col[i] = x;
               track_row[i] = y;
               res.track_id = ctia_pkg::track_id_type'(i);
            end
         end
      end
      if (!hit) begin
         if (track_count < TABLE_DEPTH) begin
            track_col[track_count] = x;
            track_row[track_count] = y;
            res.track_id = ctia_pkg::track_id_type'(track_count);
            res.is_new   = 1'b1;
            track_count++;
         end else begin
            res.dropped = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic coord_type near_coord(coord_type base, int spread);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return coord_type'(v);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (centroid_queue.size() > 0) begin
         automatic centroid_type item = centroid_queue.pop_front();
         automatic int           pick = $urandom_range(0, 99);
         start          <= 1'b1;
         req_centroid_x <= item.x;
         req_centroid_y <= item.y;
         if (no_gap || pick < 55) begin
            gap_left <= 0;
         end else if (pick < 90) begin
            gap_left <= $urandom_range(1, 3);
         end else begin
            gap_left <= $urandom_range(8, 40);
         end
      end else begin
         start <= 1'b0;
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin : monitor
      track_result_type due;
      bit               moved;
      taken = 1'b0;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            moved = 1'b1;
            if (track_results_due.size() == 0) begin
               $display("%0t unexpected transaction: track_id %0d is_new %0b dropped %0b",
                        $time, rsp_track_id, rsp_is_new, rsp_dropped);
               error_count++;
            end else begin
               due = track_results_due.pop_front();
               if (rsp_track_id !== due.track_id) begin
                  $display("%0t track_id mismatch: expected %0d actual %0d",
                           $time, due.track_id, rsp_track_id);
                  error_count++;
               end
               if (rsp_is_new !== due.is_new) begin
                  $display("%0t is_new mismatch: expected %0b actual %0b",
                           $time, due.is_new, rsp_is_new);
                  error_count++;
               end
               if (rsp_dropped !== due.dropped) begin
                  $display("%0t dropped mismatch: expected %0b actual %0b",
                           $time, due.dropped, rsp_dropped);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            taken = 1'b1;
            moved = 1'b1;
            track_results_due.insert(track_results_due.size(),
                                     assign_track(req_centroid_x, req_centroid_y));
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (!(centroid_queue.size() == 0 && !start && track_results_due.size() == 0));
   endtask

   task automatic write_radius(ctia_pkg::radius_type value);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      model_radius      = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send(int x, int y);
      centroid_type item;
      item.x = coord_type'(x);
      item.y = coord_type'(y);
      centroid_queue.insert(centroid_queue.size(), item);
   endtask

   initial begin : stimulus
      ctia_pkg::radius_type phase_radius [RANDOM_PHASES];
      centroid_type         item;
      int                   phase;
      int                   n;
      int                   pick;
      int                   k;
      int                   spread;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset radius: exact boundary, lowest id among several in range
      send(0, 0);
      send(COORD_MAX, COORD_MAX);
      send(0, 49);
      send(0, 99);
      send(35, 84);
      send(COORD_MAX, 4050);
      send(2048, 2048);

      // zero radius never matches, even on an exact duplicate
      write_radius('0);
      send(2048, 2048);
      send(0, 0);
      send(COORD_MAX, 0);

      write_radius('1);
      send(COORD_MAX, 0);
      send(0, COORD_MAX);
      send(COORD_MAX, COORD_MAX);
      send(2730, 1365);

      write_radius(ctia_pkg::radius_type'(1));
      send(2730, 1365);
      send(2730, 1365);
      send(2731, 1365);
      send(1365, 2730);

      phase_radius[0] = ctia_pkg::radius_type'($urandom_range(20, 400));
      phase_radius[1] = '0;
      phase_radius[2] = ctia_pkg::RADIUS_RESET;
      phase_radius[3] = '1;
      phase_radius[4] = ctia_pkg::radius_type'($urandom_range(0, COORD_MAX));
      phase_radius[5] = ctia_pkg::radius_type'(1);
      phase_radius[6] = ctia_pkg::radius_type'($urandom_range(2, 100));

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_radius(phase_radius[phase]);
         no_gap = (phase % 3 == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            while (centroid_queue.size() > 1) begin
               @(posedge clock);
               #1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75 && track_count > 0) begin
               // close to a stored track, sometimes just outside the radius
               k      = $urandom_range(0, track_count - 1);
               spread = int'(model_radius) + int'(model_radius) / 4;
               item.x = near_coord(track_col[k], spread);
               item.y = near_coord(track_row[k], spread);
            end else if (pick < 85) begin
               item.x = $urandom_range(0, 1) ? coord_type'(COORD_MAX) : '0;
               item.y = $urandom_range(0, 1) ? coord_type'(COORD_MAX) : '0;
            end else begin
               item.x = coord_type'($urandom_range(0, COORD_MAX));
               item.y = coord_type'($urandom_range(0, COORD_MAX));
            end
            centroid_queue.insert(centroid_queue.size(), item);
         end
      end

      wait_idle();
      repeat (80) @(posedge clock);
      if (error_count == 0 && track_results_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/ctia_pkg.sv
hdl/ctia_dist_unit.sv
hdl/centroid_track_id_assigner_top.sv
tb/sv/tb_centroid_track_id_assigner_top.sv
